FILE: sv/tqe_pkg.sv
// Shared types and constants for the team queue engine.
`default_nettype none
package tqe_pkg;

  localparam int ELEM_W    = 10;
  localparam int TEAM_IN_W = 4;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ASSIGN = 2'd0,
    MODE_ENQ    = 2'd1,
    MODE_DEQ    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [ELEM_W-1:0] elem;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [TEAM_IN_W-1:0] team;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/tqe_queue_core.sv
// Per-team FIFO pointers, team order FIFO and element storage.
`default_nettype none
module tqe_queue_core #(
  parameter int TEAMS      = 16,
  parameter int TEAM_DEPTH = 64,
  localparam int TW        = (TEAMS > 1) ? $clog2(TEAMS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire tqe_pkg::req_t              req,
  input  wire logic [TW-1:0]              req_team,
  output tqe_pkg::res_t                   res,
  output logic [tqe_pkg::ELEM_W-1:0]      rd_data
);
  import tqe_pkg::*;

  localparam int DW  = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
  localparam int CW  = $clog2(TEAM_DEPTH + 1);
  localparam int OW  = TW;
  localparam int OCW = $clog2(TEAMS + 1);
  localparam int AW  = TW + DW;
  localparam int STORE_DEPTH = TEAMS << DW;

  localparam logic [DW:0]    DEPTH_C   = (DW+1)'(TEAM_DEPTH);
  localparam logic [DW-1:0]  HEAD_LAST = DW'(TEAM_DEPTH - 1);
  localparam logic [CW-1:0]  CNT_FULL  = CW'(TEAM_DEPTH);
  localparam logic [OW:0]    ORD_C     = (OW+1)'(TEAMS);
  localparam logic [OW-1:0]  ORD_LAST  = OW'(TEAMS - 1);
  localparam logic [OCW-1:0] ORD_FULL  = OCW'(TEAMS);

  logic [DW-1:0]     head_r      [TEAMS];
  logic [CW-1:0]     count_r     [TEAMS];
  logic [TW-1:0]     ord_mem_r   [TEAMS];
  logic [ELEM_W-1:0] store_mem_r [STORE_DEPTH];
  logic [OW-1:0]     ord_head_r;
  logic [OCW-1:0]    ord_count_r;
  logic [ELEM_W-1:0] rd_data_r;

  logic [TW-1:0]     t;
  logic [DW-1:0]     head_cur;
  logic [CW-1:0]     cnt_cur;
  logic [DW:0]       tail_sum;
  logic [DW:0]       tail_wrap;
  logic [DW-1:0]     head_inc;
  logic [OW:0]       otail_sum;
  logic [OW:0]       otail_wrap;
  logic [OW-1:0]     ord_head_inc;
  logic [TW+TEAM_IN_W-1:0] team_ext;
  logic [DW-1:0]     head_nxt;
  logic [CW-1:0]     cnt_nxt;
  logic [OW-1:0]     ord_head_nxt;
  logic [OCW-1:0]    ord_count_nxt;
  logic              upd;
  logic              push;
  logic              st_we;
  logic              st_re;
  logic [AW-1:0]     st_addr;

  always_comb begin
    t        = (req.mode == MODE_DEQ) ? ord_mem_r[ord_head_r] : req_team;
    head_cur = head_r[t];
    cnt_cur  = count_r[t];
    team_ext = (TW+TEAM_IN_W)'(t);

    // head + count stays below twice the depth
    tail_sum  = (DW+1)'(head_cur) + (DW+1)'(cnt_cur);
    tail_wrap = (tail_sum >= DEPTH_C) ? tail_sum - DEPTH_C : tail_sum;
    head_inc  = (head_cur == HEAD_LAST) ? '0 : head_cur + DW'(1);

    otail_sum    = (OW+1)'(ord_head_r) + (OW+1)'(ord_count_r);
    otail_wrap   = (otail_sum >= ORD_C) ? otail_sum - ORD_C : otail_sum;
    ord_head_inc = (ord_head_r == ORD_LAST) ? '0 : ord_head_r + OW'(1);

    res.status    = ST_DONE;
    res.team      = '0;
    upd           = 1'b0;
    push          = 1'b0;
    st_we         = 1'b0;
    st_re         = 1'b0;
    st_addr       = {t, tail_wrap[DW-1:0]};
    head_nxt      = head_cur;
    cnt_nxt       = cnt_cur;
    ord_head_nxt  = ord_head_r;
    ord_count_nxt = ord_count_r;

    case (req.mode)
      MODE_ASSIGN: begin
        res.status = ST_DONE;
      end
      MODE_ENQ: begin
        if (cnt_cur == CNT_FULL) begin
          res.status = ST_FULL;
        end else begin
          upd     = 1'b1;
          st_we   = 1'b1;
          cnt_nxt = cnt_cur + CW'(1);
          if (cnt_cur == '0 && ord_count_r != ORD_FULL) begin
            push          = 1'b1;
            ord_count_nxt = ord_count_r + OCW'(1);
          end
        end
      end
      MODE_DEQ: begin
        if (ord_count_r == '0) begin
          res.status = ST_EMPTY;
        end else if (cnt_cur == '0) begin
          // stale order entry: drop it
          res.status    = ST_EMPTY;
          ord_head_nxt  = ord_head_inc;
          ord_count_nxt = ord_count_r - OCW'(1);
        end else begin
          res.status = ST_DEQ;
          res.team   = team_ext[TEAM_IN_W-1:0];
          upd        = 1'b1;
          st_re      = 1'b1;
          st_addr    = {t, head_cur};
          head_nxt   = head_inc;
          cnt_nxt    = cnt_cur - CW'(1);
          if (cnt_cur == CW'(1)) begin
            ord_head_nxt  = ord_head_inc;
            ord_count_nxt = ord_count_r - OCW'(1);
          end
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TEAMS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
      ord_head_r  <= '0;
      ord_count_r <= '0;
    end else if (step) begin
      if (req.mode == MODE_CLEAR) begin
        for (int i = 0; i < TEAMS; i++) begin
          head_r[i]  <= '0;
          count_r[i] <= '0;
        end
        ord_head_r  <= '0;
        ord_count_r <= '0;
      end else begin
        if (upd) begin
          head_r[t]  <= head_nxt;
          count_r[t] <= cnt_nxt;
        end
        ord_head_r  <= ord_head_nxt;
        ord_count_r <= ord_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && push) begin
      ord_mem_r[otail_wrap[OW-1:0]] <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (step && st_we) begin
      store_mem_r[st_addr] <= req.elem;
    end
    if (step && st_re) begin
      rd_data_r <= store_mem_r[st_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/team_queue_engine.sv
// Team queue engine: top level with intake pipeline, team map and result register.
// One request is accepted per clock while in_ready is high. The accepting edge loads
// the intake register, then the team map is read, then the queue is updated with the
// element store read and the result is loaded into the result register, where it waits,
// so the input keeps flowing while a result is held as long as a free stage is left.
// After reset the team map is swept to team 0, one entry a cycle, with in_ready low
// until all min(ELEMENT_IDS, 1024) entries are cleared.
// The single port of the team map and the single update of the queue pointers
// per cycle set the rate of one request per cycle while the output is not stalled.
`default_nettype none
module team_queue_engine #(
  parameter int TEAMS       = 16,
  parameter int ELEMENT_IDS = 1024,
  parameter int TEAM_DEPTH  = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tqe_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [tqe_pkg::ELEM_W-1:0]     in_element_id,
  input  wire logic [tqe_pkg::TEAM_IN_W-1:0]  in_team_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tqe_pkg::STATUS_W-1:0]        out_status,
  output logic [tqe_pkg::ELEM_W-1:0]          out_element,
  output logic [tqe_pkg::TEAM_IN_W-1:0]       out_team
);
  import tqe_pkg::*;

  localparam int TW         = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int MAP_DEPTH  = (ELEMENT_IDS > 1024) ? 1024 : ELEMENT_IDS;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int RSH        = 20;
  localparam int PROD_W     = ELEM_W + RSH;
  localparam int QN_W       = 2 * ELEM_W + 1;
  localparam int TEAM_CODES = 1 << TEAM_IN_W;

  // id % MAP_DEPTH via reciprocal: exact since id * MAP_DEPTH < 2**20
  localparam logic [RSH-1:0]    RECIP       = RSH'(((1 << RSH) + MAP_DEPTH - 1) / MAP_DEPTH);
  localparam logic [ELEM_W:0]   MAP_DEPTH_C = (ELEM_W+1)'(MAP_DEPTH);
  localparam logic [MAP_AW-1:0] MAP_LAST    = MAP_AW'(MAP_DEPTH - 1);

  logic [TW-1:0] team_lut [TEAM_CODES];

  genvar g;
  generate
    for (g = 0; g < TEAM_CODES; g++) begin : g_team_lut
      assign team_lut[g] = TW'(g % TEAMS);
    end
  endgenerate

  // map clearing sweep
  logic              clearing_r;
  logic [MAP_AW-1:0] clr_ptr_r;

  // intake stage
  logic              s0_v_r;
  mode_t             s0_mode_r;
  logic [ELEM_W-1:0] s0_elem_r;
  logic [TW-1:0]     s0_team_r;
  logic [ELEM_W-1:0] s0_q_r;

  // map read stage
  logic              s1_v_r;
  mode_t             s1_mode_r;
  logic [ELEM_W-1:0] s1_elem_r;

  // result register
  logic              out_v_r;
  status_t           out_status_r;
  logic [TEAM_IN_W-1:0] out_team_r;

  logic [TW-1:0]     map_mem_r [MAP_DEPTH];
  logic [TW-1:0]     map_rd_r;

  logic              in_fire;
  logic              s2_free;
  logic              s1_free;
  logic              s1_adv;
  logic              s0_adv;
  logic [PROD_W-1:0] in_prod;
  logic [QN_W-1:0]   qn;
  logic [QN_W-1:0]   slot_full;
  logic [MAP_AW-1:0] slot;
  logic              map_we;
  logic              map_re;
  logic [MAP_AW-1:0] map_waddr;
  logic [TW-1:0]     map_wdata;
  req_t              core_req;
  res_t              core_res;
  logic [ELEM_W-1:0] core_rd;

  assign s2_free  = !out_v_r || out_ready;
  assign s1_adv   = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s0_adv   = s0_v_r && s1_free;
  assign in_ready = (!s0_v_r || s1_free) && !clearing_r;
  assign in_fire  = in_valid && in_ready;

  assign in_prod   = PROD_W'(in_element_id) * PROD_W'(RECIP);
  assign qn        = QN_W'(s0_q_r) * QN_W'(MAP_DEPTH_C);
  assign slot_full = QN_W'(s0_elem_r) - qn;
  assign slot      = slot_full[MAP_AW-1:0];

  assign map_we    = clearing_r || (s0_adv && s0_mode_r == MODE_ASSIGN);
  assign map_re    = s0_adv && s0_mode_r == MODE_ENQ;
  assign map_waddr = clearing_r ? clr_ptr_r : slot;
  assign map_wdata = clearing_r ? '0 : s0_team_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_ptr_r  <= '0;
    end else if (clearing_r) begin
      if (clr_ptr_r == MAP_LAST) begin
        clearing_r <= 1'b0;
      end else begin
        clr_ptr_r <= clr_ptr_r + MAP_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s0_v_r <= 1'b1;
      end else if (s0_adv) begin
        s0_v_r <= 1'b0;
      end
      if (s0_adv) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_mode_r <= mode_t'(in_mode);
      s0_elem_r <= in_element_id;
      s0_team_r <= team_lut[in_team_id];
      s0_q_r    <= in_prod[PROD_W-1:RSH];
    end
    if (s0_adv) begin
      s1_mode_r <= s0_mode_r;
      s1_elem_r <= s0_elem_r;
    end
    if (s1_adv) begin
      out_status_r <= core_res.status;
      out_team_r   <= core_res.team;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem_r[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_r <= map_mem_r[slot];
    end
  end

  assign core_req.mode = s1_mode_r;
  assign core_req.elem = s1_elem_r;

  tqe_queue_core #(
    .TEAMS      (TEAMS),
    .TEAM_DEPTH (TEAM_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .req      (core_req),
    .req_team (map_rd_r),
    .res      (core_res),
    .rd_data  (core_rd)
  );

  assign out_valid   = out_v_r;
  assign out_status  = out_status_r;
  assign out_element = (out_status_r == ST_DEQ) ? core_rd : '0;
  assign out_team    = out_team_r;

  a_accept_fills_intake: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s0_v_r)
    else $error("accepted request did not reach the intake stage");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> s1_v_r && $stable(s1_elem_r) && $stable(s1_mode_r))
    else $error("map stage lost its request during a result stall");

  a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> !s0_v_r && !s1_v_r && !out_v_r)
    else $error("request in flight during the team map sweep");

endmodule
`default_nettype wire

FILE: dv/team_queue_engine_tb.sv
// Self-checking testbench for team_queue_engine: random and directed requests vs. a predictor.
`timescale 1ns / 1ps
module team_queue_engine_tb;
  import tqe_pkg::*;

  localparam int TEAMS       = 16;
  localparam int ELEMENT_IDS = 1024;
  localparam int TEAM_DEPTH  = 64;
  localparam int N_RANDOM    = 600;
  localparam int LIMIT       = 1000000;

  typedef struct {
    mode_t                mode;
    logic [ELEM_W-1:0]    elem;
    logic [TEAM_IN_W-1:0] team;
    int unsigned          gap;
    bit                   drain;  // hold until every outstanding result is back
  } request_t;

  typedef struct {
    status_t              status;
    logic [ELEM_W-1:0]    elem;
    logic [TEAM_IN_W-1:0] team;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [ELEM_W-1:0]    in_element_id = '0;
  logic [TEAM_IN_W-1:0] in_team_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [ELEM_W-1:0]    out_element;
  logic [TEAM_IN_W-1:0] out_team;

  team_queue_engine #(
    .TEAMS       (TEAMS),
    .ELEMENT_IDS (ELEMENT_IDS),
    .TEAM_DEPTH  (TEAM_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_element_id (in_element_id),
    .in_team_id    (in_team_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_element   (out_element),
    .out_team      (out_team)
  );

  // predictor state
  logic [TEAM_IN_W-1:0] team_of   [ELEMENT_IDS];
  logic [ELEM_W-1:0]    team_fifo [TEAMS][TEAM_DEPTH];
  logic [5:0]           fifo_head [TEAMS];
  logic [6:0]           fifo_fill [TEAMS];
  logic [3:0]           order_fifo [TEAMS];
  logic [3:0]           order_head;
  logic [4:0]           order_fill;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  request_t    offered;
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cycles = 0;
  bit          long_hold_done = 1'b0;
  bit          zero_gap = 1'b0;

  function automatic outcome_t team_queue_step(request_t r);
    outcome_t   res;
    logic [3:0] t;
    logic [5:0] pos;
    logic [3:0] opos;
    res.status = ST_DONE;
    res.elem   = '0;
    res.team   = '0;
    case (r.mode)
      MODE_ASSIGN: team_of[r.elem] = r.team;
      MODE_ENQ: begin
        t = team_of[r.elem];
        if (fifo_fill[t] >= 7'(TEAM_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          pos = fifo_head[t] + fifo_fill[t][5:0];
          if (fifo_fill[t] == 7'd0 && order_fill < 5'(TEAMS)) begin
            opos = order_head + order_fill[3:0];
            order_fifo[opos] = t;
            order_fill = order_fill + 5'd1;
          end
          team_fifo[t][pos] = r.elem;
          fifo_fill[t] = fifo_fill[t] + 7'd1;
        end
      end
      MODE_DEQ: begin
        if (order_fill == 5'd0) begin
          res.status = ST_EMPTY;
        end else begin
          t = order_fifo[order_head];
          if (fifo_fill[t] == 7'd0) begin
            order_head = order_head + 4'd1;
            order_fill = order_fill - 5'd1;
            res.status = ST_EMPTY;
          end else begin
            res.elem   = team_fifo[t][fifo_head[t]];
            res.team   = t;
            res.status = ST_DEQ;
            fifo_head[t] = fifo_head[t] + 6'd1;
            fifo_fill[t] = fifo_fill[t] - 7'd1;
            if (fifo_fill[t] == 7'd0) begin
              order_head = order_head + 4'd1;
              order_fill = order_fill - 5'd1;
            end
          end
        end
      end
      default: begin
        foreach (fifo_head[i]) begin
          fifo_head[i] = '0;
          fifo_fill[i] = '0;
        end
        order_head = '0;
        order_fill = '0;
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (zero_gap || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(mode_t m, logic [ELEM_W-1:0] e, logic [TEAM_IN_W-1:0] t);
    request_t r;
    r.mode  = m;
    r.elem  = e;
    r.team  = t;
    r.gap   = pick_gap();
    r.drain = (n_queued == 300) || ($urandom_range(0, 99) == 0);
    pending_requests.push_back(r);
    n_queued++;
  endtask

  task automatic add_mixed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25)
      add_req(MODE_ASSIGN, ELEM_W'($urandom), TEAM_IN_W'($urandom));
    else if (r < 68)
      add_req(MODE_ENQ, ELEM_W'($urandom), TEAM_IN_W'($urandom));
    else if (r < 98)
      add_req(MODE_DEQ, ELEM_W'($urandom), TEAM_IN_W'($urandom));
    else
      add_req(MODE_CLEAR, ELEM_W'($urandom), TEAM_IN_W'($urandom));
  endtask

  // map a few ids to one team, overfill it, then pull some back out
  task automatic add_fill_burst();
    logic [ELEM_W-1:0]    ids [4];
    logic [TEAM_IN_W-1:0] t;
    int unsigned          n;
    t = TEAM_IN_W'($urandom);
    foreach (ids[i]) begin
      ids[i] = ELEM_W'($urandom);
      add_req(MODE_ASSIGN, ids[i], t);
    end
    n = $urandom_range(TEAM_DEPTH + 2, TEAM_DEPTH + 8);
    repeat (n) add_req(MODE_ENQ, ids[$urandom_range(0, 3)], TEAM_IN_W'($urandom));
    n = $urandom_range(10, 70);
    repeat (n) add_req(MODE_DEQ, ELEM_W'($urandom), TEAM_IN_W'($urandom));
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    int unsigned r;
    foreach (team_of[i]) team_of[i] = '0;
    foreach (fifo_head[i]) begin
      fifo_head[i] = '0;
      fifo_fill[i] = '0;
      order_fifo[i] = '0;
    end
    order_head = '0;
    order_fill = '0;

    // directed
    add_req(MODE_DEQ, 10'd0, 4'd0);
    add_req(MODE_ASSIGN, 10'd1023, 4'd15);
    add_req(MODE_ASSIGN, 10'd0, 4'd0);
    add_req(MODE_ASSIGN, 10'd512, 4'd15);
    add_req(MODE_ASSIGN, 10'd1, 4'd7);
    add_req(MODE_ENQ, 10'd1023, 4'd0);
    add_req(MODE_ENQ, 10'd0, 4'd15);
    add_req(MODE_ENQ, 10'd512, 4'd0);
    add_req(MODE_ENQ, 10'd1, 4'd15);
    add_req(MODE_ENQ, 10'd1023, 4'd5);
    add_req(MODE_DEQ, 10'd1023, 4'd15);
    add_req(MODE_DEQ, 10'd0, 4'd0);
    add_req(MODE_DEQ, 10'd0, 4'd0);
    add_req(MODE_CLEAR, 10'd0, 4'd0);
    add_req(MODE_DEQ, 10'd0, 4'd0);
    add_req(MODE_ENQ, 10'h2AA, 4'hA);
    add_req(MODE_ENQ, 10'h155, 4'h5);
    // remap while queued: already stored entries keep their team
    add_req(MODE_ASSIGN, 10'h155, 4'hA);
    add_req(MODE_ENQ, 10'h155, 4'h0);
    add_req(MODE_DEQ, 10'h3FF, 4'hF);
    add_req(MODE_DEQ, 10'h000, 4'h0);
    add_req(MODE_DEQ, 10'h000, 4'h0);
    add_req(MODE_DEQ, 10'h000, 4'h0);
    add_req(MODE_CLEAR, 10'h3FF, 4'hF);
    add_req(MODE_CLEAR, 10'h000, 4'h0);

    add_fill_burst();
    while (n_queued < N_RANDOM + 25) begin
      zero_gap = (n_queued >= 350 && n_queued < 430);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        add_mixed();
      end else if (r < 80) begin
        add_fill_burst();
      end else if (r < 95) begin
        repeat ($urandom_range(5, 40)) add_req(MODE_DEQ, ELEM_W'($urandom), TEAM_IN_W'($urandom));
      end else begin
        add_req(MODE_CLEAR, ELEM_W'($urandom), TEAM_IN_W'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_outcomes.push_back(team_queue_step(offered));
      if (!in_valid || in_ready) begin
        if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests[0].gap != 0) begin
          pending_requests[0].gap = pending_requests[0].gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests[0].drain && expected_outcomes.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          offered = pending_requests.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= offered.mode;
          in_element_id <= offered.elem;
          in_team_id    <= offered.team;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    outcome_t  exp_o;
    int unsigned r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result: status %0d element %0d team %0d",
                 out_status, out_element, out_team);
          n_errors++;
        end else begin
          exp_o = expected_outcomes.pop_front();
          if (out_status !== exp_o.status) begin
            $error("status: expected %0d, got %0d", exp_o.status, out_status);
            n_errors++;
          end
          if (out_element !== exp_o.elem) begin
            $error("out_element: expected %0d, got %0d", exp_o.elem, out_element);
            n_errors++;
          end
          if (out_team !== exp_o.team) begin
            $error("out_team: expected %0d, got %0d", exp_o.team, out_team);
            n_errors++;
          end
        end
        n_checked++;
      end

      if (hold_cycles != 0) begin
        hold_cycles = hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (n_checked == 100 && !long_hold_done) begin
        // long hold-off so the pipeline backs up into in_ready
        long_hold_done = 1'b1;
        hold_cycles = 300;
        out_ready <= 1'b0;
      end else if (n_checked >= 450 && n_checked < 520) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else begin
          if (r < 90) hold_cycles = $urandom_range(0, 2);
          else if (r < 98) hold_cycles = $urandom_range(3, 10);
          else hold_cycles = $urandom_range(20, 60);
          out_ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

FILE: files.f
sv/tqe_pkg.sv
sv/tqe_queue_core.sv
sv/team_queue_engine.sv
dv/team_queue_engine_tb.sv
